/* src/cfp_pkg.sv */
// Shared widths, constants and result codes of the checksum frame parser.
`timescale 1ns / 1ps

package cfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int SUM_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 3;

    localparam logic [BYTE_W-1:0]  MARKER_RESET   = 8'hF0;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'd511;
    localparam logic [COUNT_W:0]   FRAME_OVERHEAD = 10'd3;

    localparam logic [STATUS_W-1:0] ST_SUCCESS       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEVICE_ERROR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SIZE_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM_BAD  = 3'd4;

    localparam logic [KIND_W-1:0] VK_EMPTY    = 3'd0;
    localparam logic [KIND_W-1:0] VK_BYTE     = 3'd1;
    localparam logic [KIND_W-1:0] VK_HALFWORD = 3'd2;
    localparam logic [KIND_W-1:0] VK_WORD     = 3'd3;
    localparam logic [KIND_W-1:0] VK_RAW      = 3'd4;

    localparam logic [BYTE_W-1:0] LEN_BYTE     = 8'd1;
    localparam logic [BYTE_W-1:0] LEN_HALFWORD = 8'd2;
    localparam logic [BYTE_W-1:0] LEN_WORD     = 8'd4;

endpackage

/* src/cfp_ifs.sv */
// Valid/ready channel interfaces of the checksum frame parser.
`timescale 1ns / 1ps

interface cfp_cfg_if import cfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfp_in_if import cfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cfp_out_if import cfp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [BYTE_W-1:0]          payload_length;
    logic signed [VALUE_W-1:0]  value;
    logic [KIND_W-1:0]          value_kind;
    logic [BYTE_W-1:0]          error_code;
    logic                       error_code_valid;

    modport source (output valid, output status, output payload_length, output value,
                    output value_kind, output error_code, output error_code_valid,
                    input ready);
    modport sink   (input valid, input status, input payload_length, input value,
                    input value_kind, input error_code, input error_code_valid,
                    output ready);
endinterface

/* src/checksum_frame_parser.sv */
// Length-prefixed response frame parser with folded-sum checksum check.
// The result of a frame is registered at its final byte transfer and is valid in the cycle after it.
// Throughput: one byte per cycle while results are taken; a result that waits
// on the output stalls the input until that result transfers.
// Reset: synchronous active-low; clears frame state and output valid, and sets
// the success marker to 0xF0.
`timescale 1ns / 1ps

module checksum_frame_parser import cfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfp_cfg_if.sink    i_cfg_ch,
    cfp_in_if.sink     i_in_ch,
    cfp_out_if.source  o_out_ch
);

    logic [BYTE_W-1:0]  r_marker;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]  r_length, n_length;
    logic               r_success, n_success;
    logic [VALUE_W-1:0] r_value_shift, n_value_shift;
    logic [BYTE_W-1:0]  r_first_payload, n_first_payload;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [BYTE_W-1:0]   r_out_length;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [BYTE_W-1:0]   r_out_ecode, n_out_ecode;
    logic                r_out_evalid, n_out_evalid;

    logic               w_in_xfer;
    logic               w_last;
    logic [BYTE_W-1:0]  w_byte;
    logic [COUNT_W-1:0] w_pidx;
    logic [COUNT_W:0]   w_total;
    logic [BYTE_W-1:0]  w_fold;

    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = !r_out_valid || o_out_ch.ready;
    assign w_in_xfer      = i_in_ch.valid && i_in_ch.ready;
    assign w_last         = i_in_ch.frame_end;
    assign w_byte         = i_in_ch.data_byte;
    assign w_pidx         = r_byte_count - COUNT_W'(2);
    assign w_total        = {1'b0, r_byte_count} + (COUNT_W+1)'(1);
    assign w_fold         = r_sum[BYTE_W-1:0] + r_sum[SUM_W-1:BYTE_W];

    always_comb begin
        n_byte_count    = r_byte_count;
        n_sum           = r_sum;
        n_length        = r_length;
        n_success       = r_success;
        n_value_shift   = r_value_shift;
        n_first_payload = r_first_payload;
        if (w_last) begin
            n_byte_count    = '0;
            n_sum           = '0;
            n_length        = '0;
            n_success       = 1'b0;
            n_value_shift   = '0;
            n_first_payload = '0;
        end else begin
            if (r_byte_count == '0) begin
                n_success = (w_byte == r_marker);
            end else if (r_byte_count == COUNT_W'(1)) begin
                n_length = w_byte;
            end else begin
                if (w_pidx == '0) begin
                    n_first_payload = w_byte;
                end
                if (w_pidx < COUNT_W'(4)) begin
                    case (w_pidx[1:0])
                        2'd0:    n_value_shift[7:0]   = w_byte;
                        2'd1:    n_value_shift[15:8]  = w_byte;
                        2'd2:    n_value_shift[23:16] = w_byte;
                        default: n_value_shift[31:24] = w_byte;
                    endcase
                end
            end
            n_sum = r_sum + SUM_W'(w_byte);
            if (r_byte_count < COUNT_MAX) begin
                n_byte_count = r_byte_count + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_value  = '0;
        n_out_kind   = VK_EMPTY;
        n_out_ecode  = '0;
        n_out_evalid = 1'b0;
        if (w_total < FRAME_OVERHEAD) begin
            n_out_status = ST_TOO_SHORT;
        end else if (w_total != ({2'b00, r_length} + FRAME_OVERHEAD)) begin
            n_out_status = ST_SIZE_MISMATCH;
        end else if (w_fold != w_byte) begin
            n_out_status = ST_CHECKSUM_BAD;
        end else if (r_success) begin
            n_out_status = ST_SUCCESS;
        end else begin
            n_out_status = ST_DEVICE_ERROR;
        end
        if (n_out_status == ST_SUCCESS) begin
            case (r_length)
                '0: begin
                    n_out_kind = VK_EMPTY;
                end
                LEN_BYTE: begin
                    n_out_kind  = VK_BYTE;
                    n_out_value = {24'd0, r_value_shift[7:0]};
                end
                LEN_HALFWORD: begin
                    n_out_kind  = VK_HALFWORD;
                    n_out_value = {{16{r_value_shift[15]}}, r_value_shift[15:0]};
                end
                LEN_WORD: begin
                    n_out_kind  = VK_WORD;
                    n_out_value = r_value_shift;
                end
                default: begin
                    n_out_kind = VK_RAW;
                end
            endcase
        end else if (n_out_status == ST_DEVICE_ERROR && r_length != '0) begin
            n_out_ecode  = r_first_payload;
            n_out_evalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker        <= MARKER_RESET;
            r_byte_count    <= '0;
            r_sum           <= '0;
            r_length        <= '0;
            r_success       <= 1'b0;
            r_value_shift   <= '0;
            r_first_payload <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                r_marker <= i_cfg_ch.data;
            end
            if (w_in_xfer) begin
                r_byte_count    <= n_byte_count;
                r_sum           <= n_sum;
                r_length        <= n_length;
                r_success       <= n_success;
                r_value_shift   <= n_value_shift;
                r_first_payload <= n_first_payload;
            end
            if (w_in_xfer && w_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_last) begin
            r_out_status <= n_out_status;
            r_out_length <= r_length;
            r_out_value  <= n_out_value;
            r_out_kind   <= n_out_kind;
            r_out_ecode  <= n_out_ecode;
            r_out_evalid <= n_out_evalid;
        end
    end

    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.status           = r_out_status;
    assign o_out_ch.payload_length   = r_out_length;
    assign o_out_ch.value            = r_out_value;
    assign o_out_ch.value_kind       = r_out_kind;
    assign o_out_ch.error_code       = r_out_ecode;
    assign o_out_ch.error_code_valid = r_out_evalid;

endmodule

/* src/cfp_checker.sv */
// Port-level assertions of the checksum frame parser and their bind.
`timescale 1ns / 1ps

module cfp_checker import cfp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_frame_end,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic [VALUE_W-1:0]  i_out_value,
    input logic [KIND_W-1:0]   i_out_kind,
    input logic                i_out_evalid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_in_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_frame_end |=> i_out_valid)
        else $error("final byte transfer produced no result");

    a_value_only_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_SUCCESS |->
            i_out_kind == VK_EMPTY && i_out_value == '0)
        else $error("value set on a non-success result");

    a_ecode_only_dev_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_evalid |-> i_out_status == ST_DEVICE_ERROR)
        else $error("error code valid without device error status");

endmodule

bind checksum_frame_parser cfp_checker u_cfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_in_frame_end (i_in_ch.frame_end),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_out_status   (o_out_ch.status),
    .i_out_value    (o_out_ch.value),
    .i_out_kind     (o_out_ch.value_kind),
    .i_out_evalid   (o_out_ch.error_code_valid)
);

/* sim/cfp_frame_checker.sv */
// Frame checker: predicts each frame result from the byte transfers and compares the results.
`timescale 1ns / 1ps

module cfp_frame_checker import cfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cfp_cfg_if   i_cfg_ch,
    cfp_in_if    i_in_ch,
    cfp_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   payload_length;
        logic [VALUE_W-1:0]  value;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   error_code;
        logic                error_code_valid;
    } t_frame_result;

    t_frame_result expected_results[$];
    t_frame_result want;
    int            fail_total;

    logic [BYTE_W-1:0]  marker;
    logic [COUNT_W-1:0] byte_count;
    logic [SUM_W-1:0]   running_sum;
    logic [BYTE_W-1:0]  length_byte;
    logic               start_ok;
    logic [VALUE_W-1:0] value_shift;
    logic [BYTE_W-1:0]  first_payload;

    task automatic clear_frame();
        byte_count    = '0;
        running_sum   = '0;
        length_byte   = '0;
        start_ok      = 1'b0;
        value_shift   = '0;
        first_payload = '0;
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_frame_result       res;
        logic [COUNT_W:0]    total;
        logic [BYTE_W-1:0]   fold;
        logic [COUNT_W-1:0]  slot;
        if (!last) begin
            if (byte_count == 0) begin
                start_ok = (b == marker);
            end else if (byte_count == 1) begin
                length_byte = b;
            end else begin
                slot = byte_count - 9'd2;
                if (slot == 0) first_payload = b;
                if (slot < 4) value_shift[8*slot[1:0] +: 8] = b;
            end
            running_sum = running_sum + SUM_W'(b);
            if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
        end else begin
            total = {1'b0, byte_count} + 1'b1;
            fold  = running_sum[7:0] + running_sum[15:8];
            res   = '0;
            if (total < FRAME_OVERHEAD) res.status = ST_TOO_SHORT;
            else if (total != {2'b00, length_byte} + FRAME_OVERHEAD) res.status = ST_SIZE_MISMATCH;
            else if (fold != b) res.status = ST_CHECKSUM_BAD;
            else if (start_ok) res.status = ST_SUCCESS;
            else res.status = ST_DEVICE_ERROR;
            res.payload_length = length_byte;
            if (res.status == ST_SUCCESS) begin
                case (length_byte)
                    8'd0: begin
                        res.kind = VK_EMPTY;
                    end
                    LEN_BYTE: begin
                        res.kind  = VK_BYTE;
                        res.value = {24'b0, value_shift[7:0]};
                    end
                    LEN_HALFWORD: begin
                        res.kind  = VK_HALFWORD;
                        res.value = {{16{value_shift[15]}}, value_shift[15:0]};
                    end
                    LEN_WORD: begin
                        res.kind  = VK_WORD;
                        res.value = value_shift;
                    end
                    default: begin
                        res.kind = VK_RAW;
                    end
                endcase
            end else if (res.status == ST_DEVICE_ERROR && length_byte != 0) begin
                res.error_code       = first_payload;
                res.error_code_valid = 1'b1;
            end
            expected_results.push_back(res);
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker     = MARKER_RESET;
            fail_total = 0;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no frame outstanding");
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_ch.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_out_ch.status);
                        fail_total++;
                    end
                    if (i_out_ch.payload_length !== want.payload_length) begin
                        $error("payload_length expected %0d got %0d",
                               want.payload_length, i_out_ch.payload_length);
                        fail_total++;
                    end
                    if (i_out_ch.value !== want.value) begin
                        $error("value expected %0d got %0d",
                               $signed(want.value), i_out_ch.value);
                        fail_total++;
                    end
                    if (i_out_ch.value_kind !== want.kind) begin
                        $error("value_kind expected %0d got %0d", want.kind, i_out_ch.value_kind);
                        fail_total++;
                    end
                    if (i_out_ch.error_code !== want.error_code) begin
                        $error("error_code expected %0d got %0d",
                               want.error_code, i_out_ch.error_code);
                        fail_total++;
                    end
                    if (i_out_ch.error_code_valid !== want.error_code_valid) begin
                        $error("error_code_valid expected %0d got %0d",
                               want.error_code_valid, i_out_ch.error_code_valid);
                        fail_total++;
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) absorb_byte(i_in_ch.data_byte, i_in_ch.frame_end);
            if (i_cfg_ch.valid && i_cfg_ch.ready) marker = i_cfg_ch.data;
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

/* sim/tb_checksum_frame_parser.sv */
// Testbench top of the checksum frame parser: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_checksum_frame_parser import cfp_pkg::*; ();

    localparam int STALL_LIMIT = 2000;

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_SIZE, FR_SHORT, FR_NOISE, FR_LONG} t_frame_mode;

    logic i_clk;
    logic i_rst_n;

    cfp_cfg_if cfg_ch ();
    cfp_in_if  in_ch ();
    cfp_out_if out_ch ();

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int marker_writes = 0;
    int quiet_cycles  = 0;

    logic [BYTE_W-1:0] cur_marker = MARKER_RESET;
    logic [BYTE_W-1:0] frame_q[$];

    checksum_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (cfg_ch),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    cfp_frame_checker u_frame_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_ch     (cfg_ch),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("checksum_frame_parser verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.frame_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic emit_frame();
        foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
        frame_q.delete();
        frames_sent++;
    endtask

    function automatic void append_checksum(input bit good);
        logic [SUM_W-1:0]  sum;
        logic [BYTE_W-1:0] fold;
        sum = '0;
        foreach (frame_q[k]) sum = sum + SUM_W'(frame_q[k]);
        fold = sum[7:0] + sum[15:8];
        if (!good) fold = fold + 8'($urandom_range(255, 1));
        frame_q.push_back(fold);
    endfunction

    // hold the byte stream until every outstanding result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic rotate_marker();
        logic [BYTE_W-1:0] v;
        drain_results();
        case (marker_writes % 4)
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'($urandom);
            default: v = MARKER_RESET;
        endcase
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_marker = v;
        marker_writes++;
    endtask

    task automatic send_random_frame(input t_frame_mode mode, input int force_len);
        int                r;
        int                plen;
        int                nbytes;
        int                delta;
        logic [BYTE_W-1:0] start;
        r = $urandom_range(99);
        if (r < 55) start = cur_marker;
        else if (r < 65) start = cur_marker ^ (8'd1 << $urandom_range(7));
        else start = 8'($urandom);
        r = $urandom_range(99);
        if (force_len >= 0) plen = force_len;
        else if (r < 15) plen = 0;
        else if (r < 30) plen = 1;
        else if (r < 45) plen = 2;
        else if (r < 62) plen = 4;
        else if (r < 66) plen = 3;
        else if (r < 93) plen = $urandom_range(16, 5);
        else plen = $urandom_range(40, 17);
        frame_q.delete();
        case (mode)
            FR_SHORT: begin
                repeat ($urandom_range(2, 1)) frame_q.push_back(8'($urandom));
            end
            FR_NOISE: begin
                repeat ($urandom_range(12, 3)) frame_q.push_back(8'($urandom));
            end
            default: begin
                frame_q.push_back(start);
                frame_q.push_back(8'(plen));
                nbytes = plen;
                if (mode == FR_SIZE) begin
                    delta = int'($urandom_range(6)) - 3;
                    if (delta == 0) delta = 1;
                    nbytes = (plen + delta < 0) ? plen + 1 : plen + delta;
                end else if (mode == FR_LONG) begin
                    nbytes = $urandom_range(520, 509);
                end
                repeat (nbytes) frame_q.push_back(8'($urandom));
                append_checksum(mode == FR_GOOD
                                || (mode != FR_BAD_SUM && $urandom_range(99) < 70));
            end
        endcase
        emit_frame();
    endtask

    task automatic run_phase(input int byte_goal);
        int          r;
        t_frame_mode mode;
        while (bytes_sent < byte_goal) begin
            r = $urandom_range(99);
            if (r < 70) mode = FR_GOOD;
            else if (r < 80) mode = FR_BAD_SUM;
            else if (r < 90) mode = FR_SIZE;
            else if (r < 95) mode = FR_SHORT;
            else mode = FR_NOISE;
            send_random_frame(mode, -1);
            if (frames_sent % 45 == 0) rotate_marker();
            else if (frames_sent % 31 == 0) drain_results();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.frame_end = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 67;
        frame_q = '{8'hF0, 8'h00};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'hF0, 8'h01, 8'hFF};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'hF0, 8'h02, 8'h00, 8'h80};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'hF0, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'h5A, 8'h01, 8'h2A};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'h5A, 8'h00};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'hF0, 8'h00};
        append_checksum(1'b0);
        emit_frame();
        frame_q = '{8'hF0, 8'h05};
        append_checksum(1'b1);
        emit_frame();
        frame_q = '{8'hF0};
        emit_frame();
        frame_q = '{8'hF0, 8'h00};
        emit_frame();

        rotate_marker();
        run_phase(450);

        send_idle_pct = 67;
        recv_idle_pct = 38;
        rotate_marker();
        run_phase(850);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        rotate_marker();
        run_phase(1130);
        send_random_frame(FR_GOOD, 255);
        send_random_frame(FR_LONG, int'($urandom_range(255)));

        drain_results();
        repeat (4) @(negedge i_clk);
        $display("Ran %0d frames (%0d bytes) under three pacing mixes with %0d marker writes,",
                 frames_sent, bytes_sent, marker_writes);
        $display("including short, mismatched, bad-sum, device-error and oversized frames.");
        if (fail_count == 0) begin
            $display("checksum_frame_parser verification clean");
        end else begin
            $display("checksum_frame_parser verification failed");
        end
        $finish;
    end

endmodule
